FILE: rtl/core/mailbox_ipc_slot_store_assert.svh
// ----------------------------------------------------------------------------
// Mailbox slot store assertion macros
// Shared property forms used by the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef MAILBOX_IPC_SLOT_STORE_ASSERT_SVH
`define MAILBOX_IPC_SLOT_STORE_ASSERT_SVH

// The condition c holds in the same cycle as a.
`define MBX_ASSERT_IMPLY(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (c)) \
        else $error("mailbox slot store: same-cycle check failed");

// The condition c holds in the cycle after a.
`define MBX_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (c)) \
        else $error("mailbox slot store: next-cycle check failed");

`endif

FILE: rtl/core/mbx_pkg.sv
// ----------------------------------------------------------------------------
// Mailbox slot store package
// Sizes, codes, slot entry layout and helper functions shared by the modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mbx_pkg;

    localparam int NUM_BOXES     = 16;
    localparam int SLOTS_PER_BOX = 8;
    localparam int MSG_BYTES     = 8;

    localparam int ID_W     = 4;
    localparam int SIZE_W   = 4;
    localparam int DATA_W   = 64;
    localparam int STATUS_W = 3;

    localparam int BOX_W     = (NUM_BOXES > 1) ? $clog2(NUM_BOXES) : 1;
    localparam int SLOT_W    = (SLOTS_PER_BOX > 1) ? $clog2(SLOTS_PER_BOX) : 1;
    localparam int CNT_W     = $clog2(SLOTS_PER_BOX + 1);
    localparam int ADDR_W    = BOX_W + SLOT_W;
    localparam int MEM_DEPTH = 2 ** ADDR_W;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS_PER_BOX - 1);
    localparam logic [SIZE_W-1:0] MAX_SIZE  = SIZE_W'(MSG_BYTES);

    typedef enum logic [1:0] {
        REQ_ALLOC = 2'd0,
        REQ_FREE  = 2'd1,
        REQ_SEND  = 2'd2,
        REQ_RECV  = 2'd3
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_BAD_ID    = 3'd1,
        ST_NOT_ALLOC = 3'd2,
        ST_ALREADY   = 3'd3,
        ST_FULL      = 3'd4,
        ST_NO_MATCH  = 3'd5
    } t_status;

    // One stored message. The age is its position in the box's arrival order.
    typedef struct packed {
        logic [ID_W-1:0]   sender;
        logic [SIZE_W-1:0] size;
        logic [DATA_W-1:0] payload;
        logic [SLOT_W-1:0] age;
    } t_entry;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        t_entry            data;
    } t_mem_wr;

    typedef struct packed {
        logic              clear;
        logic              sample;
        logic [SLOT_W-1:0] slot;
    } t_pick_ctl;

    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] slot;
        logic [SLOT_W-1:0] age;
        logic [SIZE_W-1:0] size;
        logic [DATA_W-1:0] payload;
    } t_pick;

    function automatic logic [DATA_W-1:0] byte_mask(input logic [SIZE_W-1:0] n);
        logic [DATA_W-1:0] m;
        m = '0;
        for (int i = 0; i < DATA_W / 8; i++) begin
            if (SIZE_W'(i) < n) begin
                m[i*8 +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

    function automatic logic [SIZE_W-1:0] cap_size(input logic [SIZE_W-1:0] s);
        return (s > MAX_SIZE) ? MAX_SIZE : s;
    endfunction

    function automatic logic id_ok(input logic [ID_W-1:0] id);
        return 32'(id) < NUM_BOXES;
    endfunction

endpackage

FILE: rtl/core/mbx_slot_mem.sv
// ----------------------------------------------------------------------------
// Mailbox slot memory
// Message slots of all boxes: one write port and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mbx_slot_mem import mbx_pkg::*; (
    input  logic              i_clk,
    input  t_mem_wr           i_wr,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output t_entry            o_rd_data
);

    t_entry r_mem [MEM_DEPTH];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/core/mbx_pick.sv
// ----------------------------------------------------------------------------
// Mailbox oldest-match unit
// Age comparator shared by the oldest-match search and the age shift pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mbx_pick import mbx_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_pick_ctl       i_ctl,
    input  t_entry          i_entry,
    input  logic            i_used,
    input  logic [ID_W-1:0] i_peer,
    output t_pick           o_best,
    output logic            o_younger
);

    t_pick r_best;
    t_pick n_best;
    logic  w_older;
    logic  w_match;

    // The single age comparator: entry against the current best.
    assign w_older = i_entry.age < r_best.age;
    assign w_match = i_used && (i_entry.sender == i_peer) && (!r_best.found || w_older);

    // During the shift pass the best holds the taken message's age.
    assign o_younger = i_used && !w_older && (i_entry.age != r_best.age);

    always_comb begin
        n_best = r_best;
        if (i_ctl.clear) begin
            n_best.found = 1'b0;
        end else if (i_ctl.sample && w_match) begin
            n_best = '{found:   1'b1,
                       slot:    i_ctl.slot,
                       age:     i_entry.age,
                       size:    i_entry.size,
                       payload: i_entry.payload};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best.found <= 1'b0;
        end else begin
            r_best <= n_best;
        end
    end

    assign o_best = r_best;

endmodule

FILE: rtl/core/mbx_seq.sv
// ----------------------------------------------------------------------------
// Mailbox sequencer
// Request decode, box state, slot occupancy, slot scans and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mbx_seq import mbx_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [1:0]          i_req_type,
    input  logic [ID_W-1:0]     i_box_id,
    input  logic [ID_W-1:0]     i_peer_id,
    input  logic [SIZE_W-1:0]   i_msg_size,
    input  logic [DATA_W-1:0]   i_msg_data,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [STATUS_W-1:0] o_status,
    output logic [DATA_W-1:0]   o_out_data,
    output logic [SIZE_W-1:0]   o_out_size,
    output t_mem_wr             o_wr,
    output logic [ADDR_W-1:0]   o_rd_addr,
    input  t_entry              i_rd_data,
    output t_pick_ctl           o_pick_ctl,
    output logic [ID_W-1:0]     o_peer,
    output logic                o_used,
    input  t_pick               i_best,
    input  logic                i_younger
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_EVAL = 7'b0000010,
        S_SEND = 7'b0000100,
        S_FIND = 7'b0001000,
        S_TAKE = 7'b0010000,
        S_AGE  = 7'b0100000,
        S_FIN  = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    t_req   r_req, n_req;
    logic [BOX_W-1:0]  r_box, n_box;
    logic              r_id_ok, n_id_ok;
    logic [ID_W-1:0]   r_peer, n_peer;
    logic              r_peer_ok, n_peer_ok;
    logic [SIZE_W-1:0] r_size, n_size;
    logic [DATA_W-1:0] r_data, n_data;

    logic                     r_alloc [NUM_BOXES];
    logic [CNT_W-1:0]         r_cnt   [NUM_BOXES];
    logic [SLOTS_PER_BOX-1:0] r_used  [NUM_BOXES];

    logic [SLOT_W-1:0] r_slot, n_slot;
    logic              r_issuing, n_issuing;
    logic              r_rd_vld, n_rd_vld;
    logic [SLOT_W-1:0] r_rd_slot, n_rd_slot;

    t_status           r_res_status, n_res_status;
    logic [DATA_W-1:0] r_res_data, n_res_data;
    logic [SIZE_W-1:0] r_res_size, n_res_size;

    logic                r_out_valid, n_out_valid;
    t_status             r_out_status, n_out_status;
    logic [DATA_W-1:0]   r_out_data, n_out_data;
    logic [SIZE_W-1:0]   r_out_size, n_out_size;

    logic              w_box_set;
    logic              w_box_clr;
    logic              w_used_set;
    logic              w_used_clr;
    logic [SLOT_W-1:0] w_used_slot;
    logic              w_cnt_inc;
    logic              w_cnt_dec;
    logic [SIZE_W-1:0] w_take_size;
    t_entry            w_aged;

    assign w_take_size = (r_size < i_best.size) ? r_size : i_best.size;

    always_comb begin
        w_aged     = i_rd_data;
        w_aged.age = i_rd_data.age - SLOT_W'(1);
    end

    always_comb begin
        n_state      = r_state;
        n_req        = r_req;
        n_box        = r_box;
        n_id_ok      = r_id_ok;
        n_peer       = r_peer;
        n_peer_ok    = r_peer_ok;
        n_size       = r_size;
        n_data       = r_data;
        n_slot       = r_slot;
        n_issuing    = r_issuing;
        n_rd_vld     = 1'b0;
        n_rd_slot    = r_rd_slot;
        n_res_status = r_res_status;
        n_res_data   = r_res_data;
        n_res_size   = r_res_size;
        n_out_valid  = r_out_valid && i_stall;
        n_out_status = r_out_status;
        n_out_data   = r_out_data;
        n_out_size   = r_out_size;
        w_box_set    = 1'b0;
        w_box_clr    = 1'b0;
        w_used_set   = 1'b0;
        w_used_clr   = 1'b0;
        w_used_slot  = r_slot;
        w_cnt_inc    = 1'b0;
        w_cnt_dec    = 1'b0;
        o_wr         = '0;
        o_pick_ctl   = '0;

        // Read issue shared by the search and the shift pass: one slot a cycle,
        // data comes back in the next cycle tagged with its slot.
        if (r_state inside {S_FIND, S_AGE}) begin
            if (r_issuing) begin
                n_rd_vld  = 1'b1;
                n_rd_slot = r_slot;
                if (r_slot == LAST_SLOT) begin
                    n_issuing = 1'b0;
                end else begin
                    n_slot = r_slot + SLOT_W'(1);
                end
            end
        end

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_req     = t_req'(i_req_type);
                    n_box     = BOX_W'(i_box_id);
                    n_id_ok   = id_ok(i_box_id);
                    n_peer    = i_peer_id;
                    n_peer_ok = id_ok(i_peer_id);
                    n_size    = cap_size(i_msg_size);
                    n_data    = i_msg_data;
                    n_state   = S_EVAL;
                end
            end
            S_EVAL: begin
                n_res_status = ST_OK;
                n_res_data   = '0;
                n_res_size   = '0;
                n_slot       = '0;
                n_state      = S_FIN;
                if (!r_id_ok) begin
                    n_res_status = ST_BAD_ID;
                end else begin
                    case (r_req)
                        REQ_ALLOC: begin
                            if (r_alloc[r_box]) begin
                                n_res_status = ST_ALREADY;
                            end else begin
                                w_box_set = 1'b1;
                            end
                        end
                        REQ_FREE: begin
                            if (r_alloc[r_box]) begin
                                w_box_clr = 1'b1;
                            end
                        end
                        REQ_SEND: begin
                            if (!r_alloc[r_box]) begin
                                n_res_status = ST_NOT_ALLOC;
                            end else begin
                                n_state = S_SEND;
                            end
                        end
                        REQ_RECV: begin
                            if (!r_peer_ok) begin
                                n_res_status = ST_BAD_ID;
                            end else if (!r_alloc[r_box]) begin
                                n_res_status = ST_NOT_ALLOC;
                            end else begin
                                o_pick_ctl.clear = 1'b1;
                                n_issuing        = 1'b1;
                                n_state          = S_FIND;
                            end
                        end
                        default: begin
                            n_res_status = ST_BAD_ID;
                        end
                    endcase
                end
            end
            S_SEND: begin
                // Lowest free slot wins; the new message goes to the back.
                if (!r_used[r_box][r_slot]) begin
                    o_wr.en           = 1'b1;
                    o_wr.addr         = {r_box, r_slot};
                    o_wr.data.sender  = r_peer;
                    o_wr.data.size    = r_size;
                    o_wr.data.payload = r_data & byte_mask(r_size);
                    o_wr.data.age     = SLOT_W'(r_cnt[r_box]);
                    w_used_set        = 1'b1;
                    w_cnt_inc         = 1'b1;
                    n_state           = S_FIN;
                end else if (r_slot == LAST_SLOT) begin
                    n_res_status = ST_FULL;
                    n_state      = S_FIN;
                end else begin
                    n_slot = r_slot + SLOT_W'(1);
                end
            end
            S_FIND: begin
                o_pick_ctl.sample = r_rd_vld;
                o_pick_ctl.slot   = r_rd_slot;
                if (r_rd_vld && (r_rd_slot == LAST_SLOT)) begin
                    n_state = S_TAKE;
                end
            end
            S_TAKE: begin
                if (!i_best.found) begin
                    n_res_status = ST_NO_MATCH;
                    n_state      = S_FIN;
                end else begin
                    w_used_clr  = 1'b1;
                    w_used_slot = i_best.slot;
                    n_res_size  = w_take_size;
                    n_res_data  = i_best.payload & byte_mask(w_take_size);
                    n_slot      = '0;
                    n_issuing   = 1'b1;
                    n_state     = S_AGE;
                end
            end
            S_AGE: begin
                // Messages that arrived after the taken one move up by one.
                if (r_rd_vld && i_younger) begin
                    o_wr.en   = 1'b1;
                    o_wr.addr = {r_box, r_rd_slot};
                    o_wr.data = w_aged;
                end
                if (r_rd_vld && (r_rd_slot == LAST_SLOT)) begin
                    w_cnt_dec = 1'b1;
                    n_state   = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_out_valid || !i_stall) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_data   = r_res_data;
                    n_out_size   = r_res_size;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_issuing   <= 1'b0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
            for (int b = 0; b < NUM_BOXES; b++) begin
                r_alloc[b] <= 1'b0;
                r_cnt[b]   <= '0;
                r_used[b]  <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_issuing   <= n_issuing;
            r_rd_vld    <= n_rd_vld;
            r_out_valid <= n_out_valid;
            if (w_box_set || w_box_clr) begin
                r_alloc[r_box] <= w_box_set;
                r_cnt[r_box]   <= '0;
                r_used[r_box]  <= '0;
            end
            if (w_used_set) begin
                r_used[r_box][w_used_slot] <= 1'b1;
            end
            if (w_used_clr) begin
                r_used[r_box][w_used_slot] <= 1'b0;
            end
            if (w_cnt_inc) begin
                r_cnt[r_box] <= r_cnt[r_box] + CNT_W'(1);
            end else if (w_cnt_dec && (r_cnt[r_box] != '0)) begin
                r_cnt[r_box] <= r_cnt[r_box] - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_req        <= n_req;
        r_box        <= n_box;
        r_id_ok      <= n_id_ok;
        r_peer       <= n_peer;
        r_peer_ok    <= n_peer_ok;
        r_size       <= n_size;
        r_data       <= n_data;
        r_slot       <= n_slot;
        r_rd_slot    <= n_rd_slot;
        r_res_status <= n_res_status;
        r_res_data   <= n_res_data;
        r_res_size   <= n_res_size;
        r_out_status <= n_out_status;
        r_out_data   <= n_out_data;
        r_out_size   <= n_out_size;
    end

    assign o_stall    = (r_state != S_IDLE);
    assign o_valid    = r_out_valid;
    assign o_status   = r_out_status;
    assign o_out_data = r_out_data;
    assign o_out_size = r_out_size;
    assign o_rd_addr  = {r_box, r_slot};
    assign o_peer     = r_peer;
    assign o_used     = r_used[r_box][r_rd_slot];

endmodule

FILE: rtl/core/mailbox_ipc_slot_store.sv
// ----------------------------------------------------------------------------
// Mailbox slot store
// Per-process mailboxes with allocate, free, send and selective receive.
//
//   Channel  Direction  Handshake          Payload
//   request  in         i_valid / o_stall  i_req_type i_box_id i_peer_id
//                                          i_msg_size i_msg_data
//   result   out        o_valid / i_stall  o_status o_out_data o_out_size
//
// Allocate, free and rejected requests pass through the evaluate and finish
// states to the result. Send scans the box's occupancy one slot per cycle.
// Receive reads the slot memory one slot per cycle through its single read
// port, once to find the oldest match and, if one is found, once more to shift
// later ages.
// One request is in work at a time.
// A finished result waits in the output register while the next is accepted.
// Reset is synchronous; all boxes come out unallocated and empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "mailbox_ipc_slot_store_assert.svh"

module mailbox_ipc_slot_store import mbx_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [1:0]          i_req_type,
    input  logic [ID_W-1:0]     i_box_id,
    input  logic [ID_W-1:0]     i_peer_id,
    input  logic [SIZE_W-1:0]   i_msg_size,
    input  logic [DATA_W-1:0]   i_msg_data,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [STATUS_W-1:0] o_status,
    output logic [DATA_W-1:0]   o_out_data,
    output logic [SIZE_W-1:0]   o_out_size
);

    t_mem_wr           w_wr;
    logic [ADDR_W-1:0] w_rd_addr;
    t_entry            w_rd_data;
    t_pick_ctl         w_pick_ctl;
    logic [ID_W-1:0]   w_peer;
    logic              w_used;
    t_pick             w_best;
    logic              w_younger;

    mbx_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_req_type (i_req_type),
        .i_box_id   (i_box_id),
        .i_peer_id  (i_peer_id),
        .i_msg_size (i_msg_size),
        .i_msg_data (i_msg_data),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_status   (o_status),
        .o_out_data (o_out_data),
        .o_out_size (o_out_size),
        .o_wr       (w_wr),
        .o_rd_addr  (w_rd_addr),
        .i_rd_data  (w_rd_data),
        .o_pick_ctl (w_pick_ctl),
        .o_peer     (w_peer),
        .o_used     (w_used),
        .i_best     (w_best),
        .i_younger  (w_younger)
    );

    mbx_slot_mem u_mem (
        .i_clk     (i_clk),
        .i_wr      (w_wr),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    mbx_pick u_pick (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_pick_ctl),
        .i_entry   (w_rd_data),
        .i_used    (w_used),
        .i_peer    (w_peer),
        .o_best    (w_best),
        .o_younger (w_younger)
    );

    // Slot memory is only written while a request is in work.
    `MBX_ASSERT_IMPLY(a_wr_busy, i_clk, i_rst_n, w_wr.en, o_stall)
    // A request that is accepted keeps the block busy in the next cycle.
    `MBX_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, i_valid && !o_stall, o_stall)
    // Only a successful receive carries data.
    `MBX_ASSERT_IMPLY(a_err_no_data, i_clk, i_rst_n, o_valid && (o_status != ST_OK), (o_out_data == '0) && (o_out_size == '0))
    // Delivered size never exceeds the message limit.
    `MBX_ASSERT_IMPLY(a_size_cap, i_clk, i_rst_n, o_valid, o_out_size <= MAX_SIZE)

endmodule

FILE: test/tb_mailbox_ipc_slot_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mailbox slot store testbench
// Drives allocate, free, send and receive requests into the mailbox store.
// A behavioral copy of the mailboxes predicts every reply, and a monitor
// compares each accepted reply with the oldest prediction. Both handshakes see
// random idle cycles, with phases that run without any.
// ----------------------------------------------------------------------------

module tb_mailbox_ipc_slot_store;
    import mbx_pkg::*;

    typedef struct packed {
        t_status           status;
        logic [DATA_W-1:0] data;
        logic [SIZE_W-1:0] size;
    } t_reply;

    localparam int TOTAL_SLOTS = NUM_BOXES * SLOTS_PER_BOX;

    logic                i_clk      = 1'b0;
    logic                i_rst_n    = 1'b0;
    logic                i_valid    = 1'b0;
    logic                o_stall;
    logic [1:0]          i_req_type = REQ_ALLOC;
    logic [ID_W-1:0]     i_box_id   = '0;
    logic [ID_W-1:0]     i_peer_id  = '0;
    logic [SIZE_W-1:0]   i_msg_size = '0;
    logic [DATA_W-1:0]   i_msg_data = '0;
    logic                o_valid;
    logic                i_stall    = 1'b0;
    logic [STATUS_W-1:0] o_status;
    logic [DATA_W-1:0]   o_out_data;
    logic [SIZE_W-1:0]   o_out_size;

    // Behavioral copy of the mailboxes; bit arrays start out cleared.
    bit                box_live     [NUM_BOXES];
    bit [15:0]         box_arrivals [NUM_BOXES];
    bit                slot_busy    [TOTAL_SLOTS];
    bit [ID_W-1:0]     slot_from    [TOTAL_SLOTS];
    bit [SIZE_W-1:0]   slot_len     [TOTAL_SLOTS];
    bit [DATA_W-1:0]   slot_bytes   [TOTAL_SLOTS];
    bit [15:0]         slot_rank    [TOTAL_SLOTS];

    t_reply reply_q [$];

    int fail_cnt     = 0;
    int checked_cnt  = 0;
    int op_cnt [4]   = '{0, 0, 0, 0};
    int delivered    = 0;
    int full_cnt     = 0;
    int nomatch_cnt  = 0;
    bit gaps_on      = 1'b0;
    bit stall_on     = 1'b0;

    mailbox_ipc_slot_store dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_req_type (i_req_type),
        .i_box_id   (i_box_id),
        .i_peer_id  (i_peer_id),
        .i_msg_size (i_msg_size),
        .i_msg_data (i_msg_data),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_status   (o_status),
        .o_out_data (o_out_data),
        .o_out_size (o_out_size)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #10_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Mostly short pauses, now and then a long one.
    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 8);
        return $urandom_range(12, 40);
    endfunction

    function automatic logic [DATA_W-1:0] keep_bytes(input int n);
        if (n >= 8) return '1;
        return (64'd1 << (8 * n)) - 64'd1;
    endfunction

    function automatic void empty_box(input int b);
        for (int s = 0; s < SLOTS_PER_BOX; s++) begin
            slot_busy[b * SLOTS_PER_BOX + s] = 1'b0;
        end
        box_arrivals[b] = '0;
    endfunction

    // Applies one request to the mailbox copy and returns the reply it earns.
    function automatic t_reply predict_reply(input t_req op, input logic [ID_W-1:0] box,
                                             input logic [ID_W-1:0] peer,
                                             input logic [SIZE_W-1:0] size_in,
                                             input logic [DATA_W-1:0] data);
        t_reply rep;
        int     b;
        int     base;
        int     cap;
        int     k;
        int     pick;
        int     n;
        bit     found;
        rep.status = ST_OK;
        rep.data   = '0;
        rep.size   = '0;
        b    = int'(box);
        base = b * SLOTS_PER_BOX;
        cap  = (int'(size_in) > MSG_BYTES) ? MSG_BYTES : int'(size_in);
        if (b >= NUM_BOXES) begin
            rep.status = ST_BAD_ID;
        end else begin
            case (op)
                REQ_ALLOC: begin
                    if (box_live[b]) begin
                        rep.status = ST_ALREADY;
                    end else begin
                        box_live[b] = 1'b1;
                        empty_box(b);
                    end
                end
                REQ_FREE: begin
                    if (box_live[b]) begin
                        box_live[b] = 1'b0;
                        empty_box(b);
                    end
                end
                REQ_SEND: begin
                    if (!box_live[b]) begin
                        rep.status = ST_NOT_ALLOC;
                    end else begin
                        rep.status = ST_FULL;
                        for (int s = 0; s < SLOTS_PER_BOX; s++) begin
                            k = base + s;
                            if (!slot_busy[k]) begin
                                slot_busy[k]    = 1'b1;
                                slot_from[k]    = peer;
                                slot_len[k]     = SIZE_W'(cap);
                                slot_bytes[k]   = data & keep_bytes(cap);
                                slot_rank[k]    = box_arrivals[b];
                                box_arrivals[b] = box_arrivals[b] + 16'd1;
                                rep.status      = ST_OK;
                                break;
                            end
                        end
                    end
                end
                REQ_RECV: begin
                    if (int'(peer) >= NUM_BOXES) begin
                        rep.status = ST_BAD_ID;
                    end else if (!box_live[b]) begin
                        rep.status = ST_NOT_ALLOC;
                    end else begin
                        found = 1'b0;
                        pick  = 0;
                        for (int s = 0; s < SLOTS_PER_BOX; s++) begin
                            k = base + s;
                            if (slot_busy[k] && slot_from[k] == peer &&
                                (!found || slot_rank[k] < slot_rank[pick])) begin
                                found = 1'b1;
                                pick  = k;
                            end
                        end
                        if (!found) begin
                            rep.status = ST_NO_MATCH;
                        end else begin
                            n = (cap < int'(slot_len[pick])) ? cap : int'(slot_len[pick]);
                            rep.size = SIZE_W'(n);
                            rep.data = slot_bytes[pick] & keep_bytes(n);
                            slot_busy[pick] = 1'b0;
                            // Later arrivals move up one place in the order.
                            for (int s = 0; s < SLOTS_PER_BOX; s++) begin
                                k = base + s;
                                if (slot_busy[k] && slot_rank[k] > slot_rank[pick]) begin
                                    slot_rank[k] = slot_rank[k] - 16'd1;
                                end
                            end
                            if (box_arrivals[b] > 0) begin
                                box_arrivals[b] = box_arrivals[b] - 16'd1;
                            end
                        end
                    end
                end
            endcase
        end
        return rep;
    endfunction

    // Presents one request, waits for it to be taken and records its reply.
    // Valid stays high after acceptance so back-to-back requests need no toggle.
    task automatic issue_request(input t_req op, input logic [ID_W-1:0] box,
                                 input logic [ID_W-1:0] peer,
                                 input logic [SIZE_W-1:0] size,
                                 input logic [DATA_W-1:0] data);
        int     gap;
        t_reply rep;
        gap = gaps_on ? pick_idle() : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_req_type <= op;
        i_box_id   <= box;
        i_peer_id  <= peer;
        i_msg_size <= size;
        i_msg_data <= data;
        do @(posedge i_clk); while (o_stall);
        rep = predict_reply(op, box, peer, size, data);
        reply_q.push_back(rep);
        op_cnt[int'(op)]++;
        if (op == REQ_RECV && rep.status == ST_OK) delivered++;
        if (rep.status == ST_FULL) full_cnt++;
        if (rep.status == ST_NO_MATCH) nomatch_cnt++;
    endtask

    task automatic wait_replies_done();
        i_valid <= 1'b0;
        while (reply_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic report(input string field, input logic [DATA_W-1:0] want,
                          input logic [DATA_W-1:0] got);
        $display("%0t: %s mismatch: expected %h, actual %h", $time, field, want, got);
        fail_cnt++;
    endtask

    // Reply monitor.
    always @(posedge i_clk) begin : reply_check
        t_reply want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (reply_q.size() == 0) begin
                $display("%0t: unexpected reply: status %0d data %h size %0d",
                         $time, o_status, o_out_data, o_out_size);
                fail_cnt++;
            end else begin
                want = reply_q.pop_front();
                checked_cnt++;
                if (o_status !== want.status)
                    report("status", DATA_W'(want.status), DATA_W'(o_status));
                if (o_out_data !== want.data) report("out_data", want.data, o_out_data);
                if (o_out_size !== want.size)
                    report("out_size", DATA_W'(want.size), DATA_W'(o_out_size));
            end
        end
    end

    // Result-side stall generator.
    initial begin : stall_gen
        int hold;
        hold = 0;
        forever begin
            @(posedge i_clk);
            if (hold > 0) begin
                hold--;
            end else if (stall_on && $urandom_range(0, 99) < 35) begin
                i_stall <= 1'b1;
                hold = pick_idle();
            end else begin
                i_stall <= 1'b0;
                hold = $urandom_range(0, 3);
            end
        end
    end

    task automatic test_box_lifecycle();
        issue_request(REQ_RECV,  4'd0,  4'd1, 4'd8, '0);
        issue_request(REQ_SEND,  4'd0,  4'd1, 4'd8, '1);
        issue_request(REQ_FREE,  4'd3,  4'd0, 4'd0, '0);
        issue_request(REQ_ALLOC, 4'd0,  4'd0, 4'd0, '0);
        issue_request(REQ_ALLOC, 4'd0,  4'd0, 4'd0, '0);
        issue_request(REQ_ALLOC, 4'd15, 4'd0, 4'd0, '0);
        issue_request(REQ_RECV,  4'd0,  4'd1, 4'd8, '0);
    endtask

    task automatic test_selective_receive();
        // Fill all eight slots of box 0 with interleaved senders.
        issue_request(REQ_SEND, 4'd0, 4'd5,  4'd0,  '1);
        issue_request(REQ_SEND, 4'd0, 4'd9,  4'd15, '1);
        issue_request(REQ_SEND, 4'd0, 4'd5,  4'd3,  {$urandom, $urandom});
        issue_request(REQ_SEND, 4'd0, 4'd0,  4'd8,  '0);
        issue_request(REQ_SEND, 4'd0, 4'd15, 4'd8,  '1);
        issue_request(REQ_SEND, 4'd0, 4'd5,  4'd9,  {$urandom, $urandom});
        issue_request(REQ_SEND, 4'd0, 4'd9,  4'd1,  {$urandom, $urandom});
        issue_request(REQ_SEND, 4'd0, 4'd5,  4'd4,  {$urandom, $urandom});
        issue_request(REQ_SEND, 4'd0, 4'd2,  4'd8,  '1);
        // Oldest match first, truncated to the smaller of wanted and stored.
        issue_request(REQ_RECV, 4'd0, 4'd5,  4'd15, '0);
        issue_request(REQ_RECV, 4'd0, 4'd5,  4'd2,  '0);
        issue_request(REQ_RECV, 4'd0, 4'd9,  4'd8,  '0);
        // Reuses the lowest free slot but joins the back of the order.
        issue_request(REQ_SEND, 4'd0, 4'd5,  4'd6,  '1);
        issue_request(REQ_RECV, 4'd0, 4'd5,  4'd12, '0);
        issue_request(REQ_FREE, 4'd0, 4'd0,  4'd0,  '0);
        issue_request(REQ_RECV, 4'd0, 4'd5,  4'd8,  '0);
        issue_request(REQ_ALLOC, 4'd0, 4'd0, 4'd0,  '0);
        issue_request(REQ_RECV, 4'd0, 4'd5,  4'd8,  '0);
        issue_request(REQ_SEND, 4'd15, 4'd15, 4'd8, '1);
        issue_request(REQ_RECV, 4'd15, 4'd15, 4'd8, '0);
    endtask

    // Random traffic concentrated on a few boxes and senders so that boxes
    // fill up and receives find matches; the rest spreads over all ids.
    task automatic test_random_traffic(input int count);
        t_req            op;
        logic [ID_W-1:0] box;
        logic [ID_W-1:0] peer;
        int              r;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (r < 7) op = REQ_ALLOC;
            else if (r < 11) op = REQ_FREE;
            else if (r < 56) op = REQ_SEND;
            else op = REQ_RECV;
            box  = ($urandom_range(0, 99) < 75) ? ID_W'($urandom_range(0, 3))
                                                : ID_W'($urandom_range(0, 15));
            peer = ($urandom_range(0, 99) < 80) ? ID_W'($urandom_range(0, 2))
                                                : ID_W'($urandom_range(0, 15));
            issue_request(op, box, peer, SIZE_W'($urandom_range(0, 15)),
                          {$urandom, $urandom});
        end
    endtask

    task automatic test_streaming();
        gaps_on  = 1'b0;
        stall_on = 1'b0;
        test_random_traffic(400);
    endtask

    task automatic test_idle_traffic();
        gaps_on  = 1'b1;
        stall_on = 1'b1;
        test_random_traffic(600);
    endtask

    task automatic test_one_sided_idle();
        gaps_on  = 1'b1;
        stall_on = 1'b0;
        test_random_traffic(200);
        gaps_on  = 1'b0;
        stall_on = 1'b1;
        test_random_traffic(200);
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_box_lifecycle();
        test_selective_receive();
        wait_replies_done();
        test_streaming();
        test_idle_traffic();
        wait_replies_done();
        test_one_sided_idle();

        wait_replies_done();
        repeat (30) @(posedge i_clk);

        $display("Summary: %0d requests (%0d allocate, %0d free, %0d send, %0d receive), %0d replies checked.",
                 op_cnt[0] + op_cnt[1] + op_cnt[2] + op_cnt[3],
                 op_cnt[0], op_cnt[1], op_cnt[2], op_cnt[3], checked_cnt);
        $display("Summary: %0d messages delivered, %0d sends to a full box, %0d receives without a match.",
                 delivered, full_cnt, nomatch_cnt);
        if (fail_cnt == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
